// ===== hdl/lru_recency_list_macros.svh =====
// Assertion macros for the recency list block.
`ifndef LRU_RECENCY_LIST_MACROS_SVH
`define LRU_RECENCY_LIST_MACROS_SVH

`ifndef ASSERT_OFF

// Concurrent check on a named clock and active-low reset.
`define LRL_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the house clock and reset names.
`define LRL_ASSERT_STD(lbl, prop, msg) `LRL_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`else

`define LRL_ASSERT(lbl, clk, rst_n, prop, msg)
`define LRL_ASSERT_STD(lbl, prop, msg)

`endif

`endif

// ===== hdl/lrl_pkg.sv =====
// Shared types and constants for the recency list block.
package lrl_pkg;

  localparam int unsigned LRL_DEPTH       = 16;
  localparam int unsigned LRL_HANDLE_BITS = 8;
  localparam int unsigned LRL_CNT_W       = $clog2(LRL_DEPTH + 1);
  localparam int unsigned ID_W            = 16;
  localparam int unsigned CMD_W           = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT      = 3'd0,
    CMD_REMOVE_TAIL = 3'd1,
    CMD_READ_HEAD   = 3'd2,
    CMD_READ_TAIL   = 3'd3,
    CMD_REMOVE_ID   = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RDWAIT,
    S_SEARCH,
    S_SHIFT,
    S_RESP
  } state_e;

endpackage

// ===== hdl/lrl_if.sv =====
// Command and response channel interfaces of the recency list block.
interface lrl_cmd_if import lrl_pkg::*; #(
  parameter int unsigned HANDLE_BITS = LRL_HANDLE_BITS
);
  logic                   valid;
  logic                   ready;
  logic [CMD_W-1:0]       command;
  logic [ID_W-1:0]        block_id;
  logic [HANDLE_BITS-1:0] entry_handle;

  modport source (output valid, command, block_id, entry_handle, input ready);
  modport sink   (input valid, command, block_id, entry_handle, output ready);
endinterface

interface lrl_rsp_if import lrl_pkg::*; #(
  parameter int unsigned HANDLE_BITS = LRL_HANDLE_BITS,
  parameter int unsigned CNT_W       = LRL_CNT_W
);
  logic                   valid;
  logic                   ready;
  status_e                status;
  logic [ID_W-1:0]        out_block_id;
  logic [HANDLE_BITS-1:0] out_handle;
  logic [CNT_W-1:0]       entry_count;

  modport source (output valid, status, out_block_id, out_handle, entry_count, input ready);
  modport sink   (input valid, status, out_block_id, out_handle, entry_count, output ready);
endinterface

// ===== hdl/lru_recency_list.sv =====
// Recency list of cache entries: ring-buffer store plus command sequencer.
//
// Usage
//   cmd_i  : valid/ready channel carrying command, block_id and entry_handle.
//   rsp_o  : valid/ready channel carrying status, out_block_id, out_handle and
//            entry_count; exactly one response transfer per command transfer.
//   Entries sit in a single-port-read, single-port-write RAM used as a ring;
//   a head pointer marks the most recent entry, head + count - 1 the tail.
//   Insert, an unused code or an empty list goes through S_EXEC to S_RESP;
//   read head, read tail and remove tail also pass S_RDWAIT for the read
//   data; remove by id walks S_SEARCH to a match or the tail, then S_SHIFT
//   when the match is behind the head.
//   The search reads one entry per cycle; on a match the entries in front of
//   it are copied one place toward the tail, one per cycle, then the head
//   advances. The single RAM read port keeps both walks serial.
//   One command is worked on at a time; cmd_i.ready is high while idle.
//   Reset empties the list (count and head cleared); no clearing pass.
//   A stalled response is held in the output register while the next command
//   is taken and run; that command's result then waits until the slot frees.
module lru_recency_list import lrl_pkg::*; #(
  parameter int unsigned DEPTH       = LRL_DEPTH,
  parameter int unsigned HANDLE_BITS = LRL_HANDLE_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lrl_cmd_if.sink    cmd_i,
  lrl_rsp_if.source  rsp_o
);

`include "lru_recency_list_macros.svh"

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned ENT_W = ID_W + HANDLE_BITS;

  // ring position to RAM address
  function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] hd,
                                            input logic [PTR_W-1:0] p);
    logic [PTR_W:0] s;
    s = {1'b0, hd} + {1'b0, p};
    if (s >= (PTR_W+1)'(DEPTH)) s = s - (PTR_W+1)'(DEPTH);
    return s[PTR_W-1:0];
  endfunction

  state_e                 state_q, state_d;
  cmd_e                   cmd_q;
  logic [ID_W-1:0]        id_q;
  logic [HANDLE_BITS-1:0] hdl_q;
  logic [PTR_W-1:0]       head_q, head_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [PTR_W-1:0]       pos_q, pos_d;
  status_e                res_st_q, res_st_d;
  logic [ID_W-1:0]        res_id_q, res_id_d;
  logic [HANDLE_BITS-1:0] res_hdl_q, res_hdl_d;

  logic                   out_valid_q;
  status_e                out_st_q;
  logic [ID_W-1:0]        out_id_q;
  logic [HANDLE_BITS-1:0] out_hdl_q;
  logic [CNT_W-1:0]       out_cnt_q;

  logic                   ram_we, ram_re;
  logic [PTR_W-1:0]       ram_waddr, ram_raddr;
  logic [ENT_W-1:0]       ram_wdata, ram_rdata;

  logic                   cmd_fire, out_free, empty;
  logic [PTR_W-1:0]       last_pos, head_inc, head_dec;
  logic [ID_W-1:0]        rd_id;
  logic [HANDLE_BITS-1:0] rd_hdl;

  assign cmd_fire = cmd_i.valid && cmd_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;
  assign empty    = (count_q == '0);
  assign last_pos = PTR_W'(count_q - CNT_W'(1));
  assign head_inc = (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
  assign head_dec = (head_q == '0) ? PTR_W'(DEPTH - 1) : head_q - PTR_W'(1);
  assign rd_id    = ram_rdata[ENT_W-1 -: ID_W];
  assign rd_hdl   = ram_rdata[HANDLE_BITS-1:0];

  lrl_ram #(
    .DEPTH (DEPTH),
    .WIDTH (ENT_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  // command latch and working registers
  always_ff @(posedge clk_i) begin
    if (cmd_fire) begin
      cmd_q <= cmd_e'(cmd_i.command);
      id_q  <= cmd_i.block_id;
      hdl_q <= cmd_i.entry_handle;
    end
    pos_q     <= pos_d;
    res_st_q  <= res_st_d;
    res_id_q  <= res_id_d;
    res_hdl_q <= res_hdl_d;
  end

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    count_d   = count_q;
    pos_d     = pos_q;
    res_st_d  = res_st_q;
    res_id_d  = res_id_q;
    res_hdl_d = res_hdl_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_fire) state_d = S_EXEC;
      end
      S_EXEC: begin
        res_st_d  = ST_OK;
        res_id_d  = '0;
        res_hdl_d = '0;
        state_d   = S_RESP;
        unique case (cmd_q)
          CMD_INSERT: begin
            if (count_q == CNT_W'(DEPTH)) begin
              res_st_d = ST_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = head_dec;
              ram_wdata = {id_q, hdl_q};
              head_d    = head_dec;
              count_d   = count_q + CNT_W'(1);
            end
          end
          CMD_REMOVE_TAIL, CMD_READ_TAIL: begin
            if (empty) begin
              res_st_d = ST_EMPTY;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = phys(head_q, last_pos);
              state_d   = S_RDWAIT;
            end
          end
          CMD_READ_HEAD: begin
            if (empty) begin
              res_st_d = ST_EMPTY;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = head_q;
              state_d   = S_RDWAIT;
            end
          end
          CMD_REMOVE_ID: begin
            if (empty) begin
              res_st_d = ST_EMPTY;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = head_q;
              pos_d     = '0;
              state_d   = S_SEARCH;
            end
          end
          default: ;
        endcase
      end
      S_RDWAIT: begin
        res_id_d  = rd_id;
        res_hdl_d = rd_hdl;
        if (cmd_q == CMD_REMOVE_TAIL) count_d = count_q - CNT_W'(1);
        state_d = S_RESP;
      end
      S_SEARCH: begin
        // read data holds the entry at pos_q
        if (rd_id == id_q) begin
          res_id_d  = rd_id;
          res_hdl_d = rd_hdl;
          if (pos_q == '0) begin
            head_d  = head_inc;
            count_d = count_q - CNT_W'(1);
            state_d = S_RESP;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = phys(head_q, pos_q - PTR_W'(1));
            pos_d     = pos_q - PTR_W'(1);
            state_d   = S_SHIFT;
          end
        end else if (pos_q == last_pos) begin
          res_st_d = ST_NOT_FOUND;
          state_d  = S_RESP;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = phys(head_q, pos_q + PTR_W'(1));
          pos_d     = pos_q + PTR_W'(1);
        end
      end
      S_SHIFT: begin
        // move entry at pos_q one place toward the tail
        ram_we    = 1'b1;
        ram_waddr = phys(head_q, pos_q + PTR_W'(1));
        ram_wdata = ram_rdata;
        if (pos_q == '0) begin
          head_d  = head_inc;
          count_d = count_q - CNT_W'(1);
          state_d = S_RESP;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = phys(head_q, pos_q - PTR_W'(1));
          pos_d     = pos_q - PTR_W'(1);
        end
      end
      S_RESP: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // response output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_RESP && out_free) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_RESP && out_free) begin
      out_st_q  <= res_st_q;
      out_id_q  <= res_id_q;
      out_hdl_q <= res_hdl_q;
      out_cnt_q <= count_q;
    end
  end

  assign cmd_i.ready        = (state_q == S_IDLE);
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_st_q;
  assign rsp_o.out_block_id = out_id_q;
  assign rsp_o.out_handle   = out_hdl_q;
  assign rsp_o.entry_count  = out_cnt_q;

  `LRL_ASSERT_STD(a_accept_exec, cmd_fire |=> (state_q == S_EXEC), "accepted command not run")
  `LRL_ASSERT_STD(a_cnt_at_end, (count_q != $past(count_q)) |-> (state_q == S_RESP), "count moved mid-command")
  `LRL_ASSERT_STD(a_no_clash, !(ram_we && ram_re && (ram_waddr == ram_raddr)), "read and write hit one entry")
  `LRL_ASSERT_STD(a_full_cnt, (rsp_o.valid && (rsp_o.status == ST_FULL)) |-> (rsp_o.entry_count == CNT_W'(DEPTH)), "full reported below depth")
  `LRL_ASSERT_STD(a_empty_zero, (rsp_o.valid && (rsp_o.status == ST_EMPTY)) |-> ((rsp_o.entry_count == '0) && (rsp_o.out_block_id == '0)), "empty response not clean")

endmodule

// ===== hdl/lrl_ram.sv =====
// Entry store: one write port, one read port, registered read data.
module lrl_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 24
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the lru_recency_list block.
`timescale 1ns / 100ps

module testbench;
  import lrl_pkg::*;

  // Command codes 5 to 7 are not decoded by the block; it must answer them
  // with an ok status and leave the list alone.
  localparam logic [CMD_W-1:0] CMD_SPARE_5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  localparam int unsigned HND_W        = LRL_HANDLE_BITS;
  localparam int unsigned N_RANDOM     = 1410;
  localparam int unsigned QUIET_TAIL   = 150;           // last items run without gaps
  localparam int unsigned SETTLE       = 2 * LRL_DEPTH + 8;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned REPORT_CAP   = 50;

  // One response transfer, as the block presents it.
  typedef struct packed {
    status_e              status;
    logic [ID_W-1:0]      bid;
    logic [HND_W-1:0]     hnd;
    logic [LRL_CNT_W-1:0] cnt;
  } rsp_t;

  // One row of the directed part. A row is sent reps times, the handle
  // stepping by one each time. Pinned rows carry a typed-in response.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  id;
    logic [HND_W-1:0] hnd;
    logic [4:0]       reps;
    logic             pinned;
    rsp_t             want;
  } plan_row_t;

  localparam rsp_t NO_EXPECT = '{ST_OK, 16'h0000, 8'h00, 5'd0};

  localparam int unsigned NUM_PLAN = 25;
  localparam plan_row_t PLAN [NUM_PLAN] = '{
    // empty list: every read or removal reports empty, spare code is a no-op
    '{CMD_READ_HEAD,   16'h0000, 8'h00, 5'd1,  1'b1, '{ST_EMPTY, 16'h0000, 8'h00, 5'd0}},
    '{CMD_READ_TAIL,   16'h0000, 8'h00, 5'd1,  1'b1, '{ST_EMPTY, 16'h0000, 8'h00, 5'd0}},
    '{CMD_REMOVE_TAIL, 16'h0000, 8'h00, 5'd1,  1'b1, '{ST_EMPTY, 16'h0000, 8'h00, 5'd0}},
    '{CMD_REMOVE_ID,   16'hFFFF, 8'hFF, 5'd1,  1'b1, '{ST_EMPTY, 16'h0000, 8'h00, 5'd0}},
    '{CMD_SPARE_5,     16'hFFFF, 8'hFF, 5'd1,  1'b1, '{ST_OK,    16'h0000, 8'h00, 5'd0}},
    // field extremes through insert and the two reads
    '{CMD_INSERT,      16'hFFFF, 8'hFF, 5'd1,  1'b1, '{ST_OK,    16'h0000, 8'h00, 5'd1}},
    '{CMD_READ_HEAD,   16'h0000, 8'h00, 5'd1,  1'b1, '{ST_OK,    16'hFFFF, 8'hFF, 5'd1}},
    '{CMD_INSERT,      16'h0000, 8'h00, 5'd1,  1'b1, '{ST_OK,    16'h0000, 8'h00, 5'd2}},
    '{CMD_READ_TAIL,   16'h0000, 8'h00, 5'd1,  1'b1, '{ST_OK,    16'hFFFF, 8'hFF, 5'd2}},
    '{CMD_READ_HEAD,   16'hFFFF, 8'hFF, 5'd1,  1'b1, '{ST_OK,    16'h0000, 8'h00, 5'd2}},
    '{CMD_REMOVE_ID,   16'h1234, 8'h00, 5'd1,  1'b1, '{ST_NOT_FOUND, 16'h0000, 8'h00, 5'd2}},
    '{CMD_SPARE_7,     16'hBEEF, 8'hA5, 5'd1,  1'b1, '{ST_OK,    16'h0000, 8'h00, 5'd2}},
    // fill to the brim with one repeated id, then try one more
    '{CMD_INSERT,      16'hA5A5, 8'h10, 5'd14, 1'b0, NO_EXPECT},
    '{CMD_INSERT,      16'h5A5A, 8'h77, 5'd1,  1'b1, '{ST_FULL,  16'h0000, 8'h00, 5'd16}},
    '{CMD_SPARE_6,     16'h5A5A, 8'h77, 5'd1,  1'b1, '{ST_OK,    16'h0000, 8'h00, 5'd16}},
    '{CMD_READ_TAIL,   16'h0000, 8'h00, 5'd1,  1'b0, NO_EXPECT},
    // duplicate ids: the copy nearest the head goes
    '{CMD_REMOVE_ID,   16'hA5A5, 8'h00, 5'd1,  1'b0, NO_EXPECT},
    // hits at the tail, then at the new tail
    '{CMD_REMOVE_ID,   16'hFFFF, 8'h00, 5'd1,  1'b0, NO_EXPECT},
    '{CMD_REMOVE_ID,   16'h0000, 8'h00, 5'd1,  1'b0, NO_EXPECT},
    '{CMD_REMOVE_TAIL, 16'h0000, 8'h00, 5'd1,  1'b0, NO_EXPECT},
    // hit at the head
    '{CMD_INSERT,      16'h8000, 8'h80, 5'd1,  1'b0, NO_EXPECT},
    '{CMD_REMOVE_ID,   16'h8000, 8'h00, 5'd1,  1'b0, NO_EXPECT},
    // drain the rest from the tail, then underflow once more
    '{CMD_REMOVE_TAIL, 16'h0000, 8'h00, 5'd12, 1'b0, NO_EXPECT},
    '{CMD_REMOVE_TAIL, 16'h0000, 8'h00, 5'd1,  1'b1, '{ST_EMPTY, 16'h0000, 8'h00, 5'd0}},
    '{CMD_READ_TAIL,   16'h0000, 8'h00, 5'd1,  1'b1, '{ST_EMPTY, 16'h0000, 8'h00, 5'd0}}
  };

  logic clk;
  logic rst_n;

  lrl_cmd_if cmd_if ();
  lrl_rsp_if rsp_if ();

  lru_recency_list DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cmd_i  (cmd_if),
    .rsp_o  (rsp_if)
  );

  always #5 clk = ~clk;

  // Shadow copy of the recency list: position 0 is the head.
  logic [ID_W-1:0]  rec_ids  [LRL_DEPTH];
  logic [HND_W-1:0] rec_hnds [LRL_DEPTH];
  int unsigned      rec_count;

  rsp_t        awaited_responses [$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned stall_left;
  int unsigned fill_bias;     // percent chance that a random command is an insert
  bit          gaps_on;

  // Side-band that travels with a pinned directed row.
  logic pin_valid;
  rsp_t pin_rsp;

  // Apply one command to the shadow list and return the response it causes.
  function automatic rsp_t next_response(input logic [CMD_W-1:0] c,
                                         input logic [ID_W-1:0] id,
                                         input logic [HND_W-1:0] h);
    rsp_t        r;
    int unsigned i;
    int unsigned pos;
    bit          hit;
    r = '{ST_OK, '0, '0, '0};
    hit = 1'b0;
    pos = 0;
    case (c)
      CMD_INSERT: begin
        if (rec_count >= LRL_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (i = rec_count; i > 0; i--) begin
            rec_ids[i]  = rec_ids[i-1];
            rec_hnds[i] = rec_hnds[i-1];
          end
          rec_ids[0]  = id;
          rec_hnds[0] = h;
          rec_count++;
        end
      end
      CMD_REMOVE_TAIL, CMD_READ_TAIL: begin
        if (rec_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.bid = rec_ids[rec_count-1];
          r.hnd = rec_hnds[rec_count-1];
          if (c == CMD_REMOVE_TAIL) rec_count--;
        end
      end
      CMD_READ_HEAD: begin
        if (rec_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.bid = rec_ids[0];
          r.hnd = rec_hnds[0];
        end
      end
      CMD_REMOVE_ID: begin
        if (rec_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (i = 0; i < rec_count && !hit; i++) begin
            if (rec_ids[i] == id) begin
              hit = 1'b1;
              pos = i;
            end
          end
          if (!hit) begin
            r.status = ST_NOT_FOUND;
          end else begin
            r.bid = rec_ids[pos];
            r.hnd = rec_hnds[pos];
            for (i = pos; i + 1 < rec_count; i++) begin
              rec_ids[i]  = rec_ids[i+1];
              rec_hnds[i] = rec_hnds[i+1];
            end
            rec_count--;
          end
        end
      end
      default: ;  // spare codes leave the list untouched
    endcase
    r.cnt = LRL_CNT_W'(rec_count);
    return r;
  endfunction

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= REPORT_CAP)
      $display("%0t ns: %s mismatch, got 0x%0h, want 0x%0h", $time, field, got, want);
  endtask

  // Ids mostly from a small pool, so that duplicates and search hits are common.
  function automatic logic [ID_W-1:0] pick_id();
    int unsigned roll;
    roll = $urandom_range(9, 0);
    if (roll < 6) return ID_W'($urandom_range(11, 0));
    else if (roll < 7) return $urandom_range(1, 0) ? {ID_W{1'b1}} : {ID_W{1'b0}};
    else return ID_W'($urandom);
  endfunction

  task automatic pick_random(output logic [CMD_W-1:0] c, output logic [ID_W-1:0] id,
                             output logic [HND_W-1:0] h);
    int unsigned roll;
    h = HND_W'($urandom);
    id = pick_id();
    roll = $urandom_range(99, 0);
    if (roll < 3) begin
      c = CMD_W'($urandom_range(CMD_SPARE_7, CMD_SPARE_5));
    end else if ($urandom_range(99, 0) < fill_bias) begin
      c = CMD_INSERT;
    end else begin
      roll = $urandom_range(99, 0);
      if (roll < 25) c = CMD_REMOVE_TAIL;
      else if (roll < 45) c = CMD_READ_HEAD;
      else if (roll < 65) c = CMD_READ_TAIL;
      else begin
        c = CMD_REMOVE_ID;
        // mostly aim at an id that is held somewhere in the list
        if (rec_count != 0 && $urandom_range(3, 0) != 0)
          id = rec_ids[$urandom_range(rec_count - 1, 0)];
      end
    end
  endtask

  // Present one command and hold it until the block takes it. An optional
  // idle burst comes first; valid is written once per edge.
  task automatic send(input logic [CMD_W-1:0] c, input logic [ID_W-1:0] id,
                      input logic [HND_W-1:0] h, input logic pinned, input rsp_t want);
    if (gaps_on && $urandom_range(3, 0) == 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(7, 1)) @(posedge clk);
    end
    cmd_if.valid        <= 1'b1;
    cmd_if.command      <= c;
    cmd_if.block_id     <= id;
    cmd_if.entry_handle <= h;
    pin_valid           <= pinned;
    pin_rsp             <= want;
    do @(posedge clk); while (!cmd_if.ready);
  endtask

  // Sender holds off until every outstanding response has been taken.
  task automatic hold_until_drained();
    cmd_if.valid <= 1'b0;
    @(posedge clk);
    while (awaited_responses.size() != 0) @(posedge clk);
  endtask

  // Response side back-pressure in random bursts of stalled cycles.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      rsp_if.ready <= 1'b0;
    end else if (gaps_on && $urandom_range(5, 0) == 0) begin
      stall_left = $urandom_range(6, 0);
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  // Monitor: check a response transfer against the oldest expectation, then
  // predict for a command transfer on the same edge.
  always @(posedge clk) begin : monitor
    rsp_t got;
    rsp_t want;
    if (rst_n) begin
      if (rsp_if.valid && rsp_if.ready) begin
        got = '{rsp_if.status, rsp_if.out_block_id, rsp_if.out_handle, rsp_if.entry_count};
        if (awaited_responses.size() == 0) begin
          report("unexpected response, status", got.status, 0);
        end else begin
          want = awaited_responses.pop_front();
          if (got.status !== want.status) report("status", got.status, want.status);
          if (got.bid !== want.bid) report("out_block_id", got.bid, want.bid);
          if (got.hnd !== want.hnd) report("out_handle", got.hnd, want.hnd);
          if (got.cnt !== want.cnt) report("entry_count", got.cnt, want.cnt);
        end
      end
      if (cmd_if.valid && cmd_if.ready) begin
        want = next_response(cmd_if.command, cmd_if.block_id, cmd_if.entry_handle);
        if (pin_valid) want = pin_rsp;
        awaited_responses.push_back(want);
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, awaited_responses.size());
      $display("lru_recency_list verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned      r;
    int unsigned      k;
    int unsigned      n;
    logic [CMD_W-1:0] c;
    logic [ID_W-1:0]  id;
    logic [HND_W-1:0] h;
    clk                 = 1'b0;
    rst_n               = 1'b0;
    cmd_if.valid        = 1'b0;
    cmd_if.command      = CMD_INSERT;
    cmd_if.block_id     = '0;
    cmd_if.entry_handle = '0;
    rsp_if.ready        = 1'b0;
    pin_valid           = 1'b0;
    pin_rsp             = NO_EXPECT;
    rec_count           = 0;
    mismatch_count      = 0;
    cycle_count         = 0;
    stall_left          = 0;
    fill_bias           = 50;
    gaps_on             = 1'b1;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: walk the plan.
    for (r = 0; r < NUM_PLAN; r++)
      for (k = 0; k < PLAN[r].reps; k++)
        send(PLAN[r].cmd, PLAN[r].id, HND_W'(PLAN[r].hnd + k), PLAN[r].pinned, PLAN[r].want);
    hold_until_drained();

    // Random part. The insert bias swings so the list keeps travelling
    // between empty and full; gaps come and go in stretches.
    for (n = 0; n < N_RANDOM; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(2, 0))
          0:       fill_bias = 85;
          1:       fill_bias = 50;
          default: fill_bias = 20;
        endcase
      end
      if (n % 50 == 0)
        gaps_on = (n + QUIET_TAIL < N_RANDOM) && ($urandom_range(3, 0) != 0);
      if (n % 350 == 349) hold_until_drained();
      pick_random(c, id, h);
      send(c, id, h, 1'b0, NO_EXPECT);
    end

    cmd_if.valid <= 1'b0;
    while (awaited_responses.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("lru_recency_list verification clean");
    end else begin
      $display("lru_recency_list verification failed");
    end
    $finish;
  end

endmodule
